FILE: src/bitmap_block_allocator_macros.svh
// Assertion macros shared by the bitmap block allocator checkers.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bba_pkg.sv
// Package with shared constants, types and helper functions of the bitmap block allocator.
package bba_pkg;

  // Default sizing of the bitmap.
  localparam int NUM_BLOCKS_DEF      = 4096;
  localparam int WORD_BITS_DEF       = 32;
  localparam int RESERVED_BLOCKS_DEF = 10;

  // Fixed widths of the block index and of the widest bitmap word.
  localparam int INDEX_W       = 12;
  localparam int INDEX_SPAN    = 4096;
  localparam int MAX_WORD_BITS = 64;
  localparam int POS_W         = 6;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Result of a search for the lowest clear bit of a word.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } zero_hit_t;

  // Priority encoder: lowest clear bit of a word padded to the widest size.
  function automatic zero_hit_t first_zero(input logic [MAX_WORD_BITS-1:0] word);
    zero_hit_t hit;
    hit.found = 1'b0;
    hit.pos   = '0;
    for (int i = MAX_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        hit.found = 1'b1;
        hit.pos   = POS_W'(i);
      end
    end
    return hit;
  endfunction

  // Reset contents of one word: bits whose block number is below the limit are set.
  function automatic logic [MAX_WORD_BITS-1:0] reserved_word(input int base, input int limit);
    logic [MAX_WORD_BITS-1:0] word;
    for (int i = 0; i < MAX_WORD_BITS; i++) begin
      word[i] = (base + i < limit);
    end
    return word;
  endfunction

endpackage

FILE: src/bitmap_block_allocator.sv
// Bitmap block allocator: keeps one used bit per block in a RAM of WORD_BITS-bit words and
// serves allocate, free and mark requests one item at a time. After reset a clearing pass
// writes every bitmap word (NUM_WORDS words, 128 with the defaults), setting the bits of
// the reserved blocks; in_stall stays high during that pass. An allocate reads the bitmap
// one word per cycle through the single RAM read port, starting at word 0, and stops at the
// first word with a clear bit, reading up to SCAN_WORDS words (128 with the defaults). Free
// and mark pass through acceptance, a step that estimates the word number, one that corrects
// it, finds the bit and issues the RAM read, a read-modify-write and a step that hands the
// result on. A free or mark beyond the bitmap and the unused operation code go from
// acceptance straight to handing on the result. The next item is accepted as soon as the
// result sits in the output register, even while the consumer still stalls it.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS       = bba_pkg::WORD_BITS_DEF,
  parameter int RESERVED_BLOCKS = bba_pkg::RESERVED_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [bba_pkg::INDEX_W-1:0] in_block_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::INDEX_W-1:0] out_allocated_index,
  output logic                        out_status
);

  localparam int INDEX_W     = bba_pkg::INDEX_W;
  localparam int NUM_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int ALLOC_LIMIT = (NUM_BLOCKS < bba_pkg::INDEX_SPAN) ? NUM_BLOCKS
                                                                  : bba_pkg::INDEX_SPAN;
  localparam int SCAN_WORDS  = (ALLOC_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int LAST_SCAN   = SCAN_WORDS - 1;
  localparam int LAST_BITS   = ALLOC_LIMIT - LAST_SCAN * WORD_BITS;
  localparam int RESV_LIMIT  = (RESERVED_BLOCKS < NUM_BLOCKS) ? RESERVED_BLOCKS : NUM_BLOCKS;
  localparam int RECIP       = bba_pkg::INDEX_SPAN / WORD_BITS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = INDEX_W + RECIP_W;
  localparam int FULL_W      = (ADDR_W + 7 > INDEX_W) ? ADDR_W + 7 : INDEX_W;
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVQ,
    ST_DIVR,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [INDEX_W-1:0]     idx_r, idx_nxt;
  logic [RECIP_W-1:0]     quot_r, quot_nxt;
  logic [BIT_W-1:0]       bitpos_r, bitpos_nxt;
  logic [INDEX_W-1:0]     res_index_r, res_index_nxt;
  logic                   res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]     out_index_r, out_index_nxt;
  logic                   out_status_r, out_status_nxt;

  // RAM port signals.
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0]   wr_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WORD_BITS-1:0]   rd_data;

  // Datapath helpers.
  logic                   accept;
  logic                   in_range;
  logic                   out_free;
  logic [bba_pkg::MAX_WORD_BITS-1:0] pad_word;
  logic [bba_pkg::MAX_WORD_BITS-1:0] resv_word;
  bba_pkg::zero_hit_t     hit;
  logic [FULL_W-1:0]      found_full;
  logic [PROD_W-1:0]      quot_prod;
  logic [INDEX_W-1:0]     quot_back;
  logic [INDEX_W-1:0]     rem0;
  logic                   rem_over;
  logic [RECIP_W-1:0]     quot_fix;
  logic [INDEX_W-1:0]     rem_fix;
  logic [WORD_BITS-1:0]   upd_word;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bba_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall            = (state_r != ST_IDLE);
  assign accept              = in_valid && (state_r == ST_IDLE);
  assign in_range            = (32'(in_block_index) < NUM_BLOCKS);
  assign out_free            = !out_valid_r || !out_stall;
  assign out_valid           = out_valid_r;
  assign out_allocated_index = out_index_r;
  assign out_status          = out_status_r;

  // Scan word: bits beyond the allocatable range read as used; padding reads as used.
  always_comb begin
    pad_word = '1;
    if (addr_r == ADDR_W'(LAST_SCAN)) begin
      pad_word[WORD_BITS-1:0] = rd_data | ~LAST_MASK;
    end else begin
      pad_word[WORD_BITS-1:0] = rd_data;
    end
  end

  assign hit        = bba_pkg::first_zero(pad_word);
  assign found_full = FULL_W'(addr_r) * FULL_W'(WORD_BITS) + FULL_W'(hit.pos);

  // Reset contents of the word under the clearing pass.
  assign resv_word = bba_pkg::reserved_word(int'(addr_r) * WORD_BITS, RESV_LIMIT);

  // Word and bit of the given block: reciprocal multiply, then one correction step.
  assign quot_prod = PROD_W'(idx_r) * PROD_W'(RECIP);
  assign quot_back = INDEX_W'((RECIP_W + 7)'(quot_r) * (RECIP_W + 7)'(WORD_BITS));
  assign rem0      = idx_r - quot_back;
  assign rem_over  = (32'(rem0) >= WORD_BITS);
  assign quot_fix  = rem_over ? quot_r + RECIP_W'(1) : quot_r;
  assign rem_fix   = rem_over ? rem0 - INDEX_W'(WORD_BITS) : rem0;

  // Read-modify-write of one bit for free and mark.
  always_comb begin
    upd_word           = rd_data;
    upd_word[bitpos_r] = (op_r == bba_pkg::OP_MARK);
  end

  // Sequencer and output register next-state logic.
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    quot_nxt       = quot_r;
    bitpos_nxt     = bitpos_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = addr_r;
    wr_data        = upd_word;
    rd_en          = 1'b0;
    rd_addr        = addr_r;

    case (state_r)
      // Write the reset contents of every word, one word a cycle.
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = resv_word[WORD_BITS-1:0];
        if (addr_r == ADDR_W'(NUM_WORDS - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end

      // Take a new item and start its operation.
      ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_operation;
          idx_nxt        = in_block_index;
          res_index_nxt  = '0;
          res_status_nxt = bba_pkg::STATUS_OK;
          case (in_operation)
            bba_pkg::OP_ALLOC: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              addr_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            bba_pkg::OP_FREE, bba_pkg::OP_MARK: begin
              state_nxt = in_range ? ST_DIVQ : ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Estimated word number of the block.
      ST_DIVQ: begin
        quot_nxt  = quot_prod[PROD_W-1:INDEX_W];
        state_nxt = ST_DIVR;
      end

      // Corrected word number and bit position; read the word.
      ST_DIVR: begin
        rd_en      = 1'b1;
        rd_addr    = ADDR_W'(quot_fix);
        addr_nxt   = ADDR_W'(quot_fix);
        bitpos_nxt = BIT_W'(rem_fix);
        state_nxt  = ST_UPDATE;
      end

      // Write the word back with the bit set or cleared.
      ST_UPDATE: begin
        wr_en     = 1'b1;
        state_nxt = ST_DONE;
      end

      // Examine one word a cycle for a clear bit.
      ST_SCAN: begin
        if (hit.found) begin
          wr_en                     = 1'b1;
          wr_data                   = pad_word[WORD_BITS-1:0];
          wr_data[BIT_W'(hit.pos)]  = 1'b1;
          res_index_nxt             = found_full[INDEX_W-1:0];
          res_status_nxt            = bba_pkg::STATUS_OK;
          state_nxt                 = ST_DONE;
        end else if (addr_r == ADDR_W'(LAST_SCAN)) begin
          res_index_nxt  = '0;
          res_status_nxt = bba_pkg::STATUS_FULL;
          state_nxt      = ST_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = addr_r + ADDR_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = res_index_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    quot_r       <= quot_nxt;
    bitpos_r     <= bitpos_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

FILE: src/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bba_ram #(
  parameter int WIDTH = bba_pkg::WORD_BITS_DEF,
  parameter int DEPTH = bba_pkg::NUM_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/bba_checker.sv
// Port-level checker for the bitmap block allocator and its bind statement.
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_operation,
  input logic [bba_pkg::INDEX_W-1:0] in_block_index,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bba_pkg::INDEX_W-1:0] out_allocated_index,
  input logic                        out_status
);

  // A stalled result stays valid and unchanged.
  `BBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_allocated_index) && $stable(out_status), "stalled result changed")

  // A full report carries a zero index.
  `BBA_ASSERT_IMPLY(a_full_zero, clk, rst_n, out_valid && (out_status == bba_pkg::STATUS_FULL), out_allocated_index == '0, "full result with nonzero index")

  // Only one item is in work at a time.
  `BBA_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "item accepted while another is in work")

  // A new result follows a cycle in which the block was busy.
  `BBA_ASSERT_IMPLY(a_result_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared without work in progress")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
